// ===== design/cda_pkg.sv =====
`timescale 1ns / 1ps

package cda_pkg;

    localparam int DefMaxWidth  = 512;
    localparam int DefMaxHeight = 512;

    localparam logic [15:0] DIST_INF = 16'hFFFF;
    localparam logic [15:0] DIST_SAT = 16'hFFFE;

    localparam logic [9:0]  RST_WIDTH  = 10'd512;
    localparam logic [9:0]  RST_HEIGHT = 10'd512;
    localparam logic [7:0]  RST_BG     = 8'd255;
    localparam logic [7:0]  RST_ORTHO  = 8'd8;
    localparam logic [7:0]  RST_DIAG   = 8'd11;
    localparam logic [15:0] RST_RADIUS = 16'd112;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_BG     = 3'd2,
        CFG_ORTHO  = 3'd3,
        CFG_DIAG   = 3'd4,
        CFG_RADIUS = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDATA,
        S_ISSUE,
        S_EVAL,
        S_WRITE
    } state_t;

    // neighbor offsets; pass 0 is the forward raster, pass 1 the backward one
    function automatic int off_dx(input logic pass, input logic [1:0] n);
        int r;
        r = 0;
        if (!pass) begin
            case (n)
                2'd0:    r = -1;
                2'd1:    r = 0;
                2'd2:    r = 1;
                default: r = -1;
            endcase
        end else begin
            case (n)
                2'd0:    r = 1;
                2'd1:    r = -1;
                2'd2:    r = 0;
                default: r = 1;
            endcase
        end
        return r;
    endfunction

    function automatic int off_dy(input logic pass, input logic [1:0] n);
        int r;
        r = 0;
        if (!pass) begin
            r = (n == 2'd3) ? 0 : -1;
        end else begin
            r = (n == 2'd0) ? 0 : 1;
        end
        return r;
    endfunction

endpackage

// ===== design/chamfer_distance_allocation.sv =====
`timescale 1ns / 1ps

// Chamfer distance transform with class allocation over a stored image.
// Input channel (s_*): one beat per command. action 0 writes a pixel class
// (the pixel starts as a source at distance 0, or at infinity when it equals
// the background value), action 1 runs a forward and a backward 3x3 raster
// pass, action 2 reads one pixel, action 3 is dropped.
// Result channel (m_*): one beat per read: distance, allocated class and the
// within-radius flag. Config port: cfg_wr_en, cfg_index, cfg_wr_data, taken
// at once; the user must write it only while the block is idle, which the
// block does not enforce. A write goes straight into the pixel memories; a
// read passes the memory output register and then the result register. A
// run holds s_ready low for both passes; each pixel reads its own entry plus
// up to 4 in-image neighbors, one at a time over one port, then takes a
// write-back state; a source pixel skips its neighbors and writes nothing.
// Reset sets config registers to defaults and clears the control state; the
// pixel memories are not cleared and hold garbage until written.
// When m_ready is low the result register holds; writes and runs are still
// taken, a further read waits until the result register frees up.
module chamfer_distance_allocation
    import cda_pkg::*;
#(
    parameter int MAX_WIDTH  = DefMaxWidth,
    parameter int MAX_HEIGHT = DefMaxHeight
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [8:0]  s_pixel_x,
    input  logic [8:0]  s_pixel_y,
    input  logic [7:0]  s_pixel_class,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_distance,
    output logic [7:0]  m_allocated_class,
    output logic        m_within_radius
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WCW   = $clog2(MAX_WIDTH + 1);
    localparam int HCW   = $clog2(MAX_HEIGHT + 1);

    logic [15:0] dist_mem [DEPTH];
    logic [7:0]  cls_mem  [DEPTH];
    logic [15:0] q_dist;
    logic [7:0]  q_cls;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [15:0]   wr_dist;
    logic [7:0]    wr_cls;

    logic [9:0]  width_reg, height_reg;
    logic [7:0]  bg_reg, ortho_reg, diag_reg;
    logic [15:0] radius_reg;

    state_t state_reg, state_next;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic          pass_reg, pass_next;
    logic [2:0]    k_reg, k_next;
    logic [15:0]   best_reg, best_next;
    logic [7:0]    cls_reg, cls_next;
    logic          chg_reg, chg_next;
    logic          rd_in_reg, rd_in_next;

    logic          m_valid_reg, m_valid_next;
    logic [15:0]   m_dist_reg, m_dist_next;
    logic [7:0]    m_cls_reg, m_cls_next;
    logic          m_within_reg, m_within_next;

    logic [WCW-1:0] eff_w;
    logic [HCW-1:0] eff_h;
    logic           s_inside;
    logic [AW-1:0]  s_addr, here_addr;
    logic           s_fire;

    always_comb begin
        if (width_reg == 10'd0)                    eff_w = WCW'(1);
        else if (32'(width_reg) > MAX_WIDTH)       eff_w = WCW'(MAX_WIDTH);
        else                                       eff_w = WCW'(width_reg);
        if (height_reg == 10'd0)                   eff_h = HCW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)     eff_h = HCW'(MAX_HEIGHT);
        else                                       eff_h = HCW'(height_reg);
    end

    assign s_inside  = (32'(s_pixel_x) < 32'(eff_w)) && (32'(s_pixel_y) < 32'(eff_h));
    assign s_addr    = AW'(32'(s_pixel_y) * MAX_WIDTH + 32'(s_pixel_x));
    assign here_addr = AW'(32'(y_reg) * MAX_WIDTH + 32'(x_reg));

    assign s_ready = (state_reg == S_IDLE) &&
                     ((action_t'(s_action) != ACT_READ) || !m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;

    assign m_valid           = m_valid_reg;
    assign m_distance        = m_dist_reg;
    assign m_allocated_class = m_cls_reg;
    assign m_within_radius   = m_within_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            bg_reg     <= RST_BG;
            ortho_reg  <= RST_ORTHO;
            diag_reg   <= RST_DIAG;
            radius_reg <= RST_RADIUS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_wr_data[9:0];
                CFG_HEIGHT: height_reg <= cfg_wr_data[9:0];
                CFG_BG:     bg_reg     <= cfg_wr_data[7:0];
                CFG_ORTHO:  ortho_reg  <= cfg_wr_data[7:0];
                CFG_DIAG:   diag_reg   <= cfg_wr_data[7:0];
                CFG_RADIUS: radius_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            dist_mem[wr_addr] <= wr_dist;
            cls_mem[wr_addr]  <= wr_cls;
        end
        if (rd_en) begin
            q_dist <= dist_mem[rd_addr];
            q_cls  <= cls_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg        <= x_next;
        y_reg        <= y_next;
        pass_reg     <= pass_next;
        k_reg        <= k_next;
        best_reg     <= best_next;
        cls_reg      <= cls_next;
        chg_reg      <= chg_next;
        rd_in_reg    <= rd_in_next;
        m_dist_reg   <= m_dist_next;
        m_cls_reg    <= m_cls_next;
        m_within_reg <= m_within_next;
    end

    always_comb begin
        int          nx, ny;
        logic [1:0]  n;
        logic        diag;
        logic [16:0] sum;
        logic [15:0] sat;

        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        pass_next     = pass_reg;
        k_next        = k_reg;
        best_next     = best_reg;
        cls_next      = cls_reg;
        chg_next      = chg_reg;
        rd_in_next    = rd_in_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_dist_next   = m_dist_reg;
        m_cls_next    = m_cls_reg;
        m_within_next = m_within_reg;
        rd_en         = 1'b0;
        rd_addr       = here_addr;
        wr_en         = 1'b0;
        wr_addr       = here_addr;
        wr_dist       = best_reg;
        wr_cls        = cls_reg;

        n    = 2'(k_reg - 3'd1);
        nx   = int'(x_reg) + off_dx(pass_reg, n);
        ny   = int'(y_reg) + off_dy(pass_reg, n);
        diag = (off_dx(pass_reg, n) != 0) && (off_dy(pass_reg, n) != 0);
        sum  = 17'(q_dist) + 17'(diag ? diag_reg : ortho_reg);
        sat  = (sum > 17'(DIST_SAT)) ? DIST_SAT : sum[15:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (action_t'(s_action))
                        ACT_WRITE: begin
                            wr_en   = s_inside;
                            wr_addr = s_addr;
                            wr_cls  = s_pixel_class;
                            wr_dist = (s_pixel_class == bg_reg) ? DIST_INF : 16'd0;
                        end
                        ACT_RUN: begin
                            x_next     = '0;
                            y_next     = '0;
                            pass_next  = 1'b0;
                            k_next     = 3'd0;
                            state_next = S_ISSUE;
                        end
                        ACT_READ: begin
                            rd_en      = s_inside;
                            rd_addr    = s_addr;
                            rd_in_next = s_inside;
                            state_next = S_RDATA;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDATA: begin
                m_valid_next  = 1'b1;
                m_dist_next   = rd_in_reg ? q_dist : DIST_INF;
                m_cls_next    = rd_in_reg ? q_cls : 8'd0;
                m_within_next = rd_in_reg && (q_dist != DIST_INF) && (q_dist <= radius_reg);
                state_next    = S_IDLE;
            end
            S_ISSUE: begin
                if (k_reg == 3'd0) begin
                    rd_en      = 1'b1;
                    state_next = S_EVAL;
                end else if (nx >= 0 && nx < int'(eff_w) && ny >= 0 && ny < int'(eff_h)) begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(ny * MAX_WIDTH + nx);
                    state_next = S_EVAL;
                end else if (k_reg == 3'd4) begin
                    state_next = S_WRITE;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end
            S_EVAL: begin
                if (k_reg == 3'd0) begin
                    best_next = q_dist;
                    cls_next  = q_cls;
                    chg_next  = 1'b0;
                    k_next    = 3'd1;
                    // a source keeps its entry: go straight to the next pixel
                    state_next = (q_dist == 16'd0) ? S_WRITE : S_ISSUE;
                end else begin
                    if (q_dist != DIST_INF && sat < best_reg) begin
                        best_next = sat;
                        cls_next  = q_cls;
                        chg_next  = 1'b1;
                    end
                    k_next     = k_reg + 3'd1;
                    state_next = (k_reg == 3'd4) ? S_WRITE : S_ISSUE;
                end
            end
            S_WRITE: begin
                wr_en  = chg_reg;
                k_next = 3'd0;
                state_next = S_ISSUE;
                if (!pass_reg) begin
                    if (32'(x_reg) == 32'(eff_w) - 1) begin
                        x_next = '0;
                        if (32'(y_reg) == 32'(eff_h) - 1) begin
                            pass_next = 1'b1;
                            x_next    = XW'(eff_w - WCW'(1));
                            y_next    = YW'(eff_h - HCW'(1));
                        end else begin
                            y_next = y_reg + YW'(1);
                        end
                    end else begin
                        x_next = x_reg + XW'(1);
                    end
                end else begin
                    if (x_reg == '0) begin
                        x_next = XW'(eff_w - WCW'(1));
                        if (y_reg == '0) begin
                            state_next = S_IDLE;
                        end else begin
                            y_next = y_reg - YW'(1);
                        end
                    end else begin
                        x_next = x_reg - XW'(1);
                    end
                end
                // clear the change flag for the next pixel
                chg_next = 1'b0;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
